// ===== design/pidl_pkg.sv =====
// Package for the PID loop block: widths, register indexes, status codes,
// configuration and result types, and saturating add/subtract helpers.
// No dependencies.
`timescale 1ns / 1ps

package pidl_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int TOL_WIDTH   = VALUE_WIDTH - 1;
   localparam int CSR_IDX_W   = 3;

   localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_POINT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 3'd4;

   // item kinds on req_tuser
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef enum logic [1:0] {
      RUN_ACTIVE    = 2'd0,
      RUN_CONVERGED = 2'd1,
      RUN_STALLED   = 2'd2
   } run_status_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] set_point;
      logic signed [VALUE_WIDTH-1:0] gain_p;
      logic signed [VALUE_WIDTH-1:0] gain_i;
      logic signed [VALUE_WIDTH-1:0] gain_d;
      logic [TOL_WIDTH-1:0]          tolerance;
   } cfg_type;

   // first member is the most significant: error_out ends up in the low bits
   typedef struct packed {
      run_status_type                run_status;
      logic [VALUE_WIDTH-1:0]        step_count;
      logic signed [VALUE_WIDTH-1:0] plant_value;
      logic signed [VALUE_WIDTH-1:0] drive_out;
      logic signed [VALUE_WIDTH-1:0] error_out;
   } result_type;

   localparam int RSP_BITS  = $bits(result_type);
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;
   localparam int RSP_PAD   = RSP_BYTES * 8 - RSP_BITS;

   function automatic logic signed [VALUE_WIDTH-1:0] sat_add(
      input logic signed [VALUE_WIDTH-1:0] a,
      input logic signed [VALUE_WIDTH-1:0] b);
      logic signed [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         return s[VALUE_WIDTH] ? VMIN : VMAX;
      end
      return s[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] sat_sub(
      input logic signed [VALUE_WIDTH-1:0] a,
      input logic signed [VALUE_WIDTH-1:0] b);
      logic signed [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         return s[VALUE_WIDTH] ? VMIN : VMAX;
      end
      return s[VALUE_WIDTH-1:0];
   endfunction

endpackage

// ===== design/pidl_csr.sv =====
// Configuration registers of the PID loop: set point, three gains, tolerance.
// Depends on pidl_pkg.
`timescale 1ns / 1ps

module pidl_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [pidl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pidl_pkg::VALUE_WIDTH-1:0] csr_wdata,
   output pidl_pkg::cfg_type              cfg
);
   import pidl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SET_POINT: cfg_in.set_point = csr_wdata;
            CSR_GAIN_P:    cfg_in.gain_p    = csr_wdata;
            CSR_GAIN_I:    cfg_in.gain_i    = csr_wdata;
            CSR_GAIN_D:    cfg_in.gain_d    = csr_wdata;
            CSR_TOLERANCE: cfg_in.tolerance = csr_wdata[TOL_WIDTH-1:0];
            default:       cfg_in = cfg_ff;   // unknown index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/pidl_satmul.sv =====
// Saturating signed fixed-point multiply: magnitude product, truncated by
// FRAC_BITS, sign restored, clamped to the value range. Depends on pidl_pkg.
`timescale 1ns / 1ps

module pidl_satmul (
   input  logic signed [pidl_pkg::VALUE_WIDTH-1:0] a,
   input  logic signed [pidl_pkg::VALUE_WIDTH-1:0] b,
   output logic signed [pidl_pkg::VALUE_WIDTH-1:0] y
);
   import pidl_pkg::*;

   localparam int PW = 2 * VALUE_WIDTH;

   logic                     neg;
   logic [VALUE_WIDTH-1:0]   mag_a;
   logic [VALUE_WIDTH-1:0]   mag_b;
   logic [PW-1:0]            prod;
   logic [PW-FRAC_BITS-1:0]  quot;
   logic                     over;
   logic [VALUE_WIDTH-1:0]   quot_lo;

   always_comb begin
      neg     = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
      mag_a   = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
      mag_b   = b[VALUE_WIDTH-1] ? (~b + 1'b1) : b;
      prod    = {{VALUE_WIDTH{1'b0}}, mag_a} * {{VALUE_WIDTH{1'b0}}, mag_b};
      quot    = prod[PW-1:FRAC_BITS];
      // anything at or above the sign position clamps; for a negative
      // result exactly at the minimum the clamp gives the same value
      over    = |quot[PW-FRAC_BITS-1:VALUE_WIDTH-1];
      quot_lo = {1'b0, quot[VALUE_WIDTH-2:0]};
      if (over) begin
         y = neg ? VMIN : VMAX;
      end else begin
         y = neg ? (~quot_lo + 1'b1) : quot_lo;
      end
   end

endmodule

// ===== design/pidl_core.sv =====
// Loop state and the single-pass step datapath of the PID loop.
// Depends on pidl_pkg and pidl_satmul.
`timescale 1ns / 1ps

module pidl_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pidl_pkg::cfg_type                       cfg,
   input  logic                                    item_go,
   input  logic                                    item_op,
   input  logic signed [pidl_pkg::VALUE_WIDTH-1:0] item_value,
   output pidl_pkg::result_type                    result
);
   import pidl_pkg::*;

   logic signed [VALUE_WIDTH-1:0] plant_ff, plant_in;
   logic signed [VALUE_WIDTH-1:0] integral_ff, integral_in;
   logic signed [VALUE_WIDTH-1:0] last_err_ff, last_err_in;
   logic [VALUE_WIDTH-1:0]        steps_ff, steps_in;
   run_status_type                status_ff, status_in;

   logic signed [VALUE_WIDTH-1:0] err_step;
   logic signed [VALUE_WIDTH-1:0] err_start;
   logic [VALUE_WIDTH-1:0]        err_mag;
   logic signed [VALUE_WIDTH-1:0] integral_acc;
   logic signed [VALUE_WIDTH-1:0] diff;
   logic signed [VALUE_WIDTH-1:0] term_p, term_i, term_d;
   logic signed [VALUE_WIDTH-1:0] drive;
   logic signed [VALUE_WIDTH-1:0] plant_acc;
   logic signed [VALUE_WIDTH-1:0] drive_res;

   pidl_satmul u_mul_p (.a(cfg.gain_p), .b(err_step),     .y(term_p));
   pidl_satmul u_mul_i (.a(cfg.gain_i), .b(integral_acc), .y(term_i));
   pidl_satmul u_mul_d (.a(cfg.gain_d), .b(diff),         .y(term_d));

   always_comb begin
      err_step     = sat_sub(cfg.set_point, plant_ff);
      err_start    = sat_sub(cfg.set_point, item_value);
      err_mag      = err_step[VALUE_WIDTH-1] ? (~err_step + 1'b1) : err_step;
      integral_acc = sat_add(integral_ff, err_step);
      diff         = sat_sub(err_step, last_err_ff);
      drive        = sat_add(sat_add(term_p, term_i), term_d);
      plant_acc    = sat_add(plant_ff, drive);
   end

   always_comb begin
      plant_in    = plant_ff;
      integral_in = integral_ff;
      last_err_in = last_err_ff;
      steps_in    = steps_ff;
      status_in   = status_ff;
      drive_res   = '0;
      if (item_op == OP_START) begin
         plant_in    = item_value;
         integral_in = '0;
         last_err_in = '0;
         steps_in    = '0;
         status_in   = RUN_ACTIVE;
      end else if (status_ff == RUN_ACTIVE) begin
         if (err_mag <= {1'b0, cfg.tolerance}) begin
            status_in = RUN_CONVERGED;
         end else begin
            integral_in = integral_acc;
            last_err_in = err_step;
            plant_in    = plant_acc;
            drive_res   = drive;
            if (steps_ff != '1) begin
               steps_in = steps_ff + 1'b1;
            end
            if (drive == '0 || diff == '0) begin
               status_in = RUN_STALLED;
            end
         end
      end
   end

   always_comb begin
      result.error_out   = (item_op == OP_START) ? err_start : err_step;
      result.drive_out   = drive_res;
      result.plant_value = plant_in;
      result.step_count  = steps_in;
      result.run_status  = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plant_ff    <= '0;
         integral_ff <= '0;
         last_err_ff <= '0;
         steps_ff    <= '0;
         status_ff   <= RUN_ACTIVE;
      end else if (item_go) begin
         plant_ff    <= plant_in;
         integral_ff <= integral_in;
         last_err_ff <= last_err_in;
         steps_ff    <= steps_in;
         status_ff   <= status_in;
      end
   end

endmodule

// ===== design/pid_loop_with_integrating_plant.sv =====
// PID loop driving an integrating plant, signed Q16.16.
// Top level: input register, output register and handshake. Depends on
// pidl_pkg, pidl_csr and pidl_core.
//
// req_* carries items: tuser selects start (load plant value from tdata)
// or one loop step. rsp_* returns exactly one result per item, in order.
// csr_* writes the set point, gains and tolerance, one register per cycle
// with csr_we high; change them only while no item is in flight.
//
// An accepted item is registered in the input register and then in the output
// register, which drives rsp_tvalid. Throughput: one item per cycle while the
// receiver keeps rsp_tready high; the step datapath (error, three multiplies,
// drive sum, plant update) sits between the input and output registers, and
// the loop state is updated in the same cycle so the next item sees it.
//
// Reset clears the configuration, the plant value, integral, previous
// error, step count and status. When rsp_tready is low the output register
// holds its result, the input register still takes one more item, and
// req_tready then drops until the receiver frees the output register.
`timescale 1ns / 1ps

module pid_loop_with_integrating_plant (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [pidl_pkg::VALUE_WIDTH-1:0]         req_tdata,  // [31:0] start_value
   input  logic                                     req_tuser,  // [0] op
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // [31:0] error_out, [63:32] drive_out, [95:64] plant_value,
   // [127:96] step_count, [129:128] run_status, rest zero
   output logic [pidl_pkg::RSP_BYTES*8-1:0]         rsp_tdata,
   input  logic                                     csr_we,
   input  logic [pidl_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [pidl_pkg::VALUE_WIDTH-1:0]         csr_wdata
);
   import pidl_pkg::*;

   cfg_type                       cfg;
   logic                          in_valid_ff, in_valid_in;
   logic                          in_op_ff, in_op_in;
   logic signed [VALUE_WIDTH-1:0] in_value_ff, in_value_in;
   logic                          out_valid_ff, out_valid_in;
   result_type                    out_ff, out_in;
   result_type                    step_result;
   logic                          advance;
   logic                          req_fire;

   pidl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidl_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_go    (advance),
      .item_op    (in_op_ff),
      .item_value (in_value_ff),
      .result     (step_result)
   );

   // item in the input register moves to the output register
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_op_in     = in_op_ff;
      in_value_in  = in_value_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_op_in    = req_tuser;
         in_value_in = req_tdata;
      end
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff    <= in_op_in;
      in_value_ff <= in_value_in;
      out_ff      <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, out_ff};

`ifndef SYNTHESIS
   // a start transfer reports zero drive, zero count and a running loop
   assert property (@(posedge clock) disable iff (reset)
      advance && (in_op_ff == OP_START) |=>
         (out_ff.drive_out == '0) && (out_ff.step_count == '0) &&
         (out_ff.run_status == RUN_ACTIVE))
      else $error("start result not cleared");

   // a converged result never carries a drive
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.run_status == RUN_CONVERGED) |-> (out_ff.drive_out == '0))
      else $error("converged result with nonzero drive");

   // an item held in the input register is neither dropped nor overwritten
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_value_ff) && $stable(in_op_ff))
      else $error("held item lost");

   // a result waiting on the receiver stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("held result changed");
`endif

endmodule
